// ===== design/tfhd_pkg.sv =====
// Shared types and constants for the track fragment header parser.
// No dependencies; imported by every module of the block.
package tfhd_pkg;

   // Byte position counter, saturates at its all-ones value
   localparam int unsigned POS_W = 6;
   localparam logic [POS_W-1:0] POS_MAX  = '1;
   localparam logic [POS_W-1:0] HDR_LEN  = POS_W'(8);
   localparam logic [POS_W-1:0] WORD_LEN = POS_W'(4);
   localparam logic [POS_W-1:0] LONG_LEN = POS_W'(8);
   localparam logic [POS_W-1:0] ID_POS   = HDR_LEN - POS_W'(1);

   localparam logic [31:0] VERSION_MASK = 32'hff000000;

   // Presence flag bits of the optional fields
   localparam int unsigned FLAG_BASE   = 0;
   localparam int unsigned FLAG_DESC   = 1;
   localparam int unsigned FLAG_DUR    = 3;
   localparam int unsigned FLAG_SIZE   = 4;
   localparam int unsigned FLAG_SFLAGS = 5;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_TRACK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOOF      = 1'b1;

   typedef enum logic [1:0] {
      OUTCOME_PARSING = 2'd0,
      OUTCOME_OTHER   = 2'd1,
      OUTCOME_INVALID = 2'd2,
      OUTCOME_DONE    = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_OTHER   = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   // One byte handed from the input register to the parse core
   typedef struct packed {
      logic       go;
      logic       last;
      logic [7:0] data;
   } step_type;

endpackage

// ===== design/tfhd_parse_core.sv =====
// Parse core: byte position, assembler, outcome and the stored header fields.
// Depends on tfhd_pkg. One byte is consumed per cycle when step.go is high.
module tfhd_parse_core (
   input  logic                  clock,
   input  logic                  reset,
   input  tfhd_pkg::step_type    step,
   input  logic [31:0]           own_track_id,
   input  logic [63:0]           moof_offset,
   output tfhd_pkg::status_type  status_next,
   output logic [23:0]           header_flags,
   output logic [31:0]           track_id,
   output logic [31:0]           seen_track_id,
   output logic [63:0]           base_data_offset,
   output logic [31:0]           sample_desc_index,
   output logic [31:0]           default_duration,
   output logic [31:0]           default_size,
   output logic [31:0]           default_sample_flags
);
   import tfhd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [63:0]      shift_ff, shift_in, shift_new;
   outcome_type      outcome_ff, outcome_in, outcome_new;
   logic [23:0]      flags_ff, flags_in;
   logic [31:0]      tid_ff, tid_in;
   logic [31:0]      seen_ff, seen_in;
   logic [63:0]      base_ff, base_in;
   logic [31:0]      desc_ff, desc_in;
   logic [31:0]      dur_ff, dur_in;
   logic [31:0]      size_ff, size_in;
   logic [31:0]      sflags_ff, sflags_in;

   logic [31:0]      word, id;
   logic [23:0]      fsel;
   logic [POS_W-1:0] cur1, cur2, cur3, cur4, needed;
   logic [POS_W-1:0] end0, end1, end2, end3, end4;

   // Field boundaries for the active flag set
   always_comb begin
      shift_new = {shift_ff[55:0], step.data};
      word      = shift_new[63:32];
      id        = shift_new[31:0];
      fsel      = (pos_ff == ID_POS) ? word[23:0] : flags_ff;
      cur1   = HDR_LEN + (fsel[FLAG_BASE]   ? LONG_LEN : '0);
      cur2   = cur1    + (fsel[FLAG_DESC]   ? WORD_LEN : '0);
      cur3   = cur2    + (fsel[FLAG_DUR]    ? WORD_LEN : '0);
      cur4   = cur3    + (fsel[FLAG_SIZE]   ? WORD_LEN : '0);
      needed = cur4    + (fsel[FLAG_SFLAGS] ? WORD_LEN : '0);
      end0   = HDR_LEN + LONG_LEN - POS_W'(1);
      end1   = cur1 + WORD_LEN - POS_W'(1);
      end2   = cur2 + WORD_LEN - POS_W'(1);
      end3   = cur3 + WORD_LEN - POS_W'(1);
      end4   = cur4 + WORD_LEN - POS_W'(1);
   end

   // Per-byte parse step
   always_comb begin
      outcome_new = outcome_ff;
      flags_in    = flags_ff;
      tid_in      = tid_ff;
      seen_in     = seen_ff;
      base_in     = base_ff;
      desc_in     = desc_ff;
      dur_in      = dur_ff;
      size_in     = size_ff;
      sflags_in   = sflags_ff;
      if (outcome_ff == OUTCOME_PARSING) begin
         if (pos_ff == ID_POS) begin
            if ((word & VERSION_MASK) != '0) begin
               outcome_new = OUTCOME_INVALID;
            end else begin
               seen_in = id;
               if (id != own_track_id) begin
                  outcome_new = OUTCOME_OTHER;
               end else begin
                  flags_in = word[23:0];
                  tid_in   = id;
                  if (needed == HDR_LEN) begin
                     base_in     = moof_offset;
                     outcome_new = OUTCOME_DONE;
                  end
               end
            end
         end else if (pos_ff > ID_POS) begin
            if (flags_ff[FLAG_BASE] && pos_ff == end0) base_in = shift_new;
            if (flags_ff[FLAG_DESC] && pos_ff == end1) desc_in = shift_new[31:0];
            if (flags_ff[FLAG_DUR] && pos_ff == end2) dur_in = shift_new[31:0];
            if (flags_ff[FLAG_SIZE] && pos_ff == end3) size_in = shift_new[31:0];
            if (flags_ff[FLAG_SFLAGS] && pos_ff == end4) sflags_in = shift_new[31:0];
            if (pos_ff == needed - POS_W'(1)) begin
               if (!flags_ff[FLAG_BASE]) base_in = moof_offset;
               outcome_new = OUTCOME_DONE;
            end
         end
      end

      // End of box returns the framing state to zero
      if (step.last) begin
         pos_in     = '0;
         shift_in   = '0;
         outcome_in = OUTCOME_PARSING;
      end else begin
         pos_in     = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_W'(1);
         shift_in   = shift_new;
         outcome_in = outcome_new;
      end

      case (outcome_new)
         OUTCOME_DONE:  status_next = STATUS_OK;
         OUTCOME_OTHER: status_next = STATUS_OTHER;
         default:       status_next = STATUS_INVALID;
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         shift_ff   <= '0;
         outcome_ff <= OUTCOME_PARSING;
         flags_ff   <= '0;
         tid_ff     <= '0;
         seen_ff    <= '0;
         base_ff    <= '0;
         desc_ff    <= '0;
         dur_ff     <= '0;
         size_ff    <= '0;
         sflags_ff  <= '0;
      end else if (step.go) begin
         pos_ff     <= pos_in;
         shift_ff   <= shift_in;
         outcome_ff <= outcome_in;
         flags_ff   <= flags_in;
         tid_ff     <= tid_in;
         seen_ff    <= seen_in;
         base_ff    <= base_in;
         desc_ff    <= desc_in;
         dur_ff     <= dur_in;
         size_ff    <= size_in;
         sflags_ff  <= sflags_in;
      end
   end

   assign header_flags         = flags_ff;
   assign track_id             = tid_ff;
   assign seen_track_id        = seen_ff;
   assign base_data_offset     = base_ff;
   assign sample_desc_index    = desc_ff;
   assign default_duration     = dur_ff;
   assign default_size         = size_ff;
   assign default_sample_flags = sflags_ff;

endmodule

// ===== design/track_fragment_header_parser.sv =====
// Track fragment header parser, top level. A last-byte transaction on req
// passes the input and then the result register to reach rsp. Throughput:
// one byte per cycle through the parse step between those registers, unless a
// waiting result holds the core; the input register then stalls req.
// Synchronous active-high reset clears the configuration, the parse state and
// all stored fields to zero. Depends on tfhd_pkg and tfhd_parse_core.
module track_fragment_header_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [23:0]                     rsp_header_flags,
   output logic [31:0]                     rsp_track_id,
   output logic [31:0]                     rsp_seen_track_id,
   output logic [63:0]                     rsp_base_data_offset,
   output logic [31:0]                     rsp_sample_desc_index,
   output logic [31:0]                     rsp_default_duration,
   output logic [31:0]                     rsp_default_size,
   output logic [31:0]                     rsp_default_sample_flags,
   input  logic                            csr_we,
   input  logic [tfhd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [63:0]                     csr_wdata
);
   import tfhd_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff;
   status_type  status_ff, status_next;
   logic [31:0] own_track_ff;
   logic [63:0] moof_ff;
   logic        advance;
   step_type    step;

   // Core may step when the result slot is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign step.go   = advance;
   assign step.last = in_last_ff;
   assign step.data = in_data_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_track_ff <= '0;
         moof_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OWN_TRACK: own_track_ff <= csr_wdata[31:0];
            CSR_MOOF:      moof_ff      <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // Result register; fields are read straight from the held core state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         status_ff    <= STATUS_OK;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
         status_ff    <= status_next;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   tfhd_parse_core u_core (
      .clock                (clock),
      .reset                (reset),
      .step                 (step),
      .own_track_id         (own_track_ff),
      .moof_offset          (moof_ff),
      .status_next          (status_next),
      .header_flags         (rsp_header_flags),
      .track_id             (rsp_track_id),
      .seen_track_id        (rsp_seen_track_id),
      .base_data_offset     (rsp_base_data_offset),
      .sample_desc_index    (rsp_sample_desc_index),
      .default_duration     (rsp_default_duration),
      .default_size         (rsp_default_size),
      .default_sample_flags (rsp_default_sample_flags)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;

endmodule

// ===== design/tfhd_chk.sv =====
// Port-level checks for the track fragment header parser.
// Depends on tfhd_pkg; bound to track_fragment_header_parser below.
module tfhd_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [1:0]                      rsp_status,
   input logic [23:0]                     rsp_header_flags,
   input logic [31:0]                     rsp_track_id,
   input logic [31:0]                     rsp_seen_track_id,
   input logic [63:0]                     rsp_base_data_offset,
   input logic [31:0]                     rsp_sample_desc_index,
   input logic [31:0]                     rsp_default_duration,
   input logic [31:0]                     rsp_default_size,
   input logic [31:0]                     rsp_default_sample_flags
);
   import tfhd_pkg::*;

   // A stalled result keeps its transaction intact
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_header_flags) && $stable(rsp_track_id)
         && $stable(rsp_seen_track_id) && $stable(rsp_base_data_offset)
         && $stable(rsp_sample_desc_index) && $stable(rsp_default_duration)
         && $stable(rsp_default_size) && $stable(rsp_default_sample_flags))
      else $error("rsp transaction changed while stalled");

   // Input backpressure only comes from a stalled result
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without rsp backpressure");

   // Accepted box: the seen ID is the stored one
   a_ok_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_seen_track_id == rsp_track_id)
      else $error("ok status with mismatched track id");

   // Status code 3 is never reported
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_OTHER
         || rsp_status == STATUS_INVALID)
      else $error("undefined status code");

endmodule

bind track_fragment_header_parser tfhd_chk u_tfhd_chk (.*);

// ===== dv/tfhd_checker.sv =====
// Checker for the track fragment header parser: predicts each result from the
// accepted req bytes and csr writes, and compares it with the rsp channel.
// Depends on tfhd_pkg for the outcome and status codes and the flag bit layout.
module tfhd_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [1:0]                      rsp_status,
   input  logic [23:0]                     rsp_header_flags,
   input  logic [31:0]                     rsp_track_id,
   input  logic [31:0]                     rsp_seen_track_id,
   input  logic [63:0]                     rsp_base_data_offset,
   input  logic [31:0]                     rsp_sample_desc_index,
   input  logic [31:0]                     rsp_default_duration,
   input  logic [31:0]                     rsp_default_size,
   input  logic [31:0]                     rsp_default_sample_flags,
   input  logic                            csr_we,
   input  logic [tfhd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [63:0]                     csr_wdata,
   output int                              fail_count,
   output int                              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tfhd_pkg::*;

   localparam int MAX_PRINTS = 200;

   typedef struct {
      status_type  status;
      logic [23:0] flags;
      logic [31:0] track;
      logic [31:0] seen;
      logic [63:0] base;
      logic [31:0] desc;
      logic [31:0] dur;
      logic [31:0] size;
      logic [31:0] sflags;
   } header_fields_type;

   // Optional fields in box order: presence bit and byte length
   localparam int unsigned OPT_BIT [5] = '{FLAG_BASE, FLAG_DESC, FLAG_DUR, FLAG_SIZE,
                                           FLAG_SFLAGS};
   localparam int unsigned OPT_LEN [5] = '{8, 4, 4, 4, 4};

   header_fields_type expected_headers[$];

   // Configuration copy
   logic [31:0] own_track;
   logic [63:0] moof_base;

   // Parse state
   logic [POS_W-1:0]  byte_pos;
   logic [63:0]       shift_acc;
   outcome_type       outcome;
   header_fields_type kept;

   function automatic int unsigned needed_bytes(input logic [23:0] f);
      int unsigned n;
      n = 8;
      for (int i = 0; i < 5; i++)
         if (f[OPT_BIT[i]]) n += OPT_LEN[i];
      return n;
   endfunction

   task automatic clear_state();
      own_track = '0;
      moof_base = '0;
      byte_pos  = '0;
      shift_acc = '0;
      outcome   = OUTCOME_PARSING;
      kept      = '{STATUS_OK, '0, '0, '0, '0, '0, '0, '0, '0};
      expected_headers.delete();
   endtask

   // Latch an optional field whose final byte is at this position
   task automatic latch_optional(input int unsigned pos);
      int unsigned cursor;
      cursor = 8;
      for (int i = 0; i < 5; i++) begin
         if (kept.flags[OPT_BIT[i]]) begin
            if (pos == cursor + OPT_LEN[i] - 1) begin
               case (i)
                  0: kept.base = shift_acc;
                  1: kept.desc = shift_acc[31:0];
                  2: kept.dur = shift_acc[31:0];
                  3: kept.size = shift_acc[31:0];
                  default: kept.sflags = shift_acc[31:0];
               endcase
            end
            cursor += OPT_LEN[i];
         end
      end
   endtask

   task automatic close_fields();
      if (!kept.flags[FLAG_BASE]) kept.base = moof_base;
      outcome = OUTCOME_DONE;
   endtask

   // One accepted byte; a last byte queues the header it completes
   task automatic parse_byte(input logic [7:0] b, input logic last);
      header_fields_type h;
      logic [31:0] word;
      logic [31:0] id;
      shift_acc = {shift_acc[55:0], b};
      if (outcome == OUTCOME_PARSING) begin
         if (byte_pos == ID_POS) begin
            word = shift_acc[63:32];
            id   = shift_acc[31:0];
            if ((word & VERSION_MASK) != '0) begin
               outcome = OUTCOME_INVALID;
            end else begin
               kept.seen = id;
               if (id != own_track) begin
                  outcome = OUTCOME_OTHER;
               end else begin
                  kept.flags = word[23:0];
                  kept.track = id;
                  if (needed_bytes(kept.flags) == 8) close_fields();
               end
            end
         end else if (byte_pos > ID_POS) begin
            latch_optional(int'(byte_pos));
            if (int'(byte_pos) == needed_bytes(kept.flags) - 1) close_fields();
         end
      end
      if (byte_pos != POS_MAX) byte_pos++;
      if (last) begin
         h = kept;
         case (outcome)
            OUTCOME_DONE:  h.status = STATUS_OK;
            OUTCOME_OTHER: h.status = STATUS_OTHER;
            default:       h.status = STATUS_INVALID;
         endcase
         expected_headers.push_back(h);
         byte_pos  = '0;
         shift_acc = '0;
         outcome   = OUTCOME_PARSING;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (fail_count < MAX_PRINTS)
         $display("[%0t] tfhd mismatch: %s got %h expected %h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Results first, so a same-edge byte never lines up with its own result
   always @(posedge clock) begin
      header_fields_type h;
      if (reset) begin
         clear_state();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_headers.size() == 0) begin
               report_mismatch("result with nothing pending", 64'(rsp_status), '0);
            end else begin
               h = expected_headers.pop_front();
               check_field("status", 64'(rsp_status), 64'(h.status));
               check_field("header_flags", 64'(rsp_header_flags), 64'(h.flags));
               check_field("track_id", 64'(rsp_track_id), 64'(h.track));
               check_field("seen_track_id", 64'(rsp_seen_track_id), 64'(h.seen));
               check_field("base_data_offset", rsp_base_data_offset, h.base);
               check_field("sample_desc_index", 64'(rsp_sample_desc_index), 64'(h.desc));
               check_field("default_duration", 64'(rsp_default_duration), 64'(h.dur));
               check_field("default_size", 64'(rsp_default_size), 64'(h.size));
               check_field("default_sample_flags", 64'(rsp_default_sample_flags),
                           64'(h.sflags));
            end
         end
         if (req_valid && !req_stall) parse_byte(req_data_byte, req_last_byte);
         if (csr_we) begin
            case (csr_index)
               CSR_OWN_TRACK: own_track = csr_wdata[31:0];
               CSR_MOOF:      moof_base = csr_wdata;
               default: ;
            endcase
         end
      end
      pending_count = expected_headers.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the track fragment header parser: clock, reset, box
// stimulus, csr settings and the verdict. Depends on tfhd_pkg, the block and
// tfhd_checker, which predicts and compares every result.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tfhd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_BYTES  = 575;
   localparam int SETTLE_TICKS = 4;

   typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_kind_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [7:0]           req_data_byte;
   logic                 req_last_byte;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_status;
   logic [23:0]          rsp_header_flags;
   logic [31:0]          rsp_track_id;
   logic [31:0]          rsp_seen_track_id;
   logic [63:0]          rsp_base_data_offset;
   logic [31:0]          rsp_sample_desc_index;
   logic [31:0]          rsp_default_duration;
   logic [31:0]          rsp_default_size;
   logic [31:0]          rsp_default_sample_flags;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_wdata;
   int                   fail_count;
   int                   pending_count;

   int          send_idle = 0;
   int          recv_idle = 0;
   int          cycle_count = 0;
   int          bytes_sent = 0;
   int          boxes_sent = 0;
   int          kind_count [6];
   logic [31:0] own_track;

   track_fragment_header_parser DUT (.*);
   tfhd_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure
   always @(posedge clock) rsp_stall <= ($urandom_range(0, 99) < recv_idle);

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid     <= 1'b0;
         req_data_byte <= 8'($urandom);
         req_last_byte <= 1'($urandom);
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // Build one box payload; cut > 0 keeps that many bytes, cut < 0 cuts inside
   // the optional fields at a random point
   task automatic send_box(input logic [7:0] ver, input logic [23:0] flags,
                           input logic [31:0] id, input fill_kind_type fill,
                           input int extra, input int cut);
      logic [7:0]  q[$];
      logic [63:0] fld;
      int          len;
      q.push_back(ver);
      q.push_back(flags[23:16]);
      q.push_back(flags[15:8]);
      q.push_back(flags[7:0]);
      for (int k = 3; k >= 0; k--) q.push_back(id[8*k +: 8]);
      for (int i = 0; i < 5; i++) begin
         case (i)
            0: len = flags[FLAG_BASE] ? 8 : 0;
            1: len = flags[FLAG_DESC] ? 4 : 0;
            2: len = flags[FLAG_DUR] ? 4 : 0;
            3: len = flags[FLAG_SIZE] ? 4 : 0;
            default: len = flags[FLAG_SFLAGS] ? 4 : 0;
         endcase
         fld = (fill == FILL_ONES) ? '1 : (fill == FILL_ZEROS) ? '0 : {$urandom, $urandom};
         for (int k = len - 1; k >= 0; k--) q.push_back(fld[8*k +: 8]);
      end
      if (cut < 0) cut = $urandom_range(9, q.size() - 1);
      for (int k = 0; k < extra; k++)
         q.push_back((fill == FILL_ONES) ? 8'hff : (fill == FILL_ZEROS) ? 8'h00 : 8'($urandom));
      if (cut > 0 && cut < q.size()) q = q[0:cut-1];
      for (int j = 0; j < q.size(); j++) send_byte(q[j], j == q.size() - 1);
      boxes_sent++;
   endtask

   // Mostly well-formed own-track boxes, the rest other tracks and broken boxes
   task automatic random_box();
      int          r;
      logic [7:0]  ver;
      logic [23:0] flags;
      logic [31:0] id;
      int          extra;
      int          cut;
      r     = $urandom_range(0, 99);
      ver   = '0;
      flags = 24'($urandom);
      id    = own_track;
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      cut   = 0;
      if (r < 60) begin
         kind_count[0]++;
      end else if (r < 72) begin
         id = own_track ^ ($urandom | 32'd1);
         kind_count[1]++;
      end else if (r < 80) begin
         ver = 8'($urandom_range(1, 255));
         if ($urandom_range(0, 1) == 0) id = $urandom;
         kind_count[2]++;
      end else if (r < 88) begin
         cut = $urandom_range(1, 7);
         kind_count[3]++;
      end else if (r < 96) begin
         flags[FLAG_DESC] = 1'b1;
         cut = -1;
         kind_count[4]++;
      end else begin
         extra = $urandom_range(20, 50);
         kind_count[5]++;
      end
      send_box(ver, flags, id, FILL_RANDOM, extra, cut);
   endtask

   // Hold the sender until every queued header has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] track, input logic [63:0] moof);
      write_csr(CSR_OWN_TRACK, {32'h0, track});
      write_csr(CSR_MOOF, moof);
      own_track = track;
   endtask

   task automatic random_phase(input int s_idle, input int r_idle, input bit pause_midway);
      int target;
      send_idle = s_idle;
      recv_idle = r_idle;
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
         random_box();
         if (pause_midway && bytes_sent >= target - PHASE_BYTES / 2) begin
            drain_results();
            pause_midway = 1'b0;
         end
      end
      drain_results();
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      rsp_stall     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      own_track     = '0;
      foreach (kind_count[i]) kind_count[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed boxes
      set_config(32'ha5c3_0f96, 64'h0123_4567_89ab_cdef);
      send_idle = 25;
      recv_idle = 61;
      send_box(8'hff, 24'hffffff, 32'hffff_ffff, FILL_ONES, 0, 1);   // one-byte box
      send_box(8'h00, 24'h000000, own_track, FILL_RANDOM, 0, 0);     // no fields, moof base
      send_box(8'h00, 24'hffffff, own_track, FILL_ONES, 0, 0);       // all fields, spare bits
      send_box(8'h01, 24'h00003b, own_track, FILL_RANDOM, 0, 0);     // nonzero version
      send_box(8'h00, 24'h00003b, ~own_track, FILL_RANDOM, 0, 0);    // other track
      send_box(8'h00, 24'h00003b, own_track, FILL_RANDOM, 0, -1);    // cut in optional part
      send_box(8'h00, 24'h000009, own_track, FILL_ZEROS, 50, 0);     // long, counter saturates
      send_box(8'h00, 24'h000000, own_track, FILL_RANDOM, 0, 7);     // ends before track ID
      send_box(8'h00, 24'h000001, own_track, FILL_ZEROS, 0, 0);      // explicit zero base
      drain_results();

      set_config(32'h0000_0000, 64'hffff_ffff_ffff_ffff);
      random_phase(25, 61, 1'b1);
      set_config(32'hffff_ffff, 64'h0000_0000_0000_0000);
      random_phase(61, 25, 1'b0);
      set_config($urandom, {$urandom, $urandom});
      random_phase(0, 0, 1'b0);

      $display("Covered %0d boxes in %0d bytes under four track/moof settings", boxes_sent,
               bytes_sent);
      $display("Random mix: own %0d, other %0d, bad version %0d, short %0d, cut %0d, long %0d",
               kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4],
               kind_count[5]);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== track_fragment_header_parser.f =====
design/tfhd_pkg.sv
design/tfhd_parse_core.sv
design/track_fragment_header_parser.sv
design/tfhd_chk.sv
dv/tfhd_checker.sv
dv/tb_top.sv
